### design/scfs_pkg.sv
// ----------------------------------------------------------------------------
// scfs_pkg: shared types and constants of the supply command frame slave
// Command codes, controller states and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
`default_nettype none
package scfs_pkg;

   localparam int FRAME_BYTES_DEF = 20;

   localparam logic [7:0] CMD_OUTPUT   = 8'h20;
   localparam logic [7:0] CMD_SET_V    = 8'h21;
   localparam logic [7:0] CMD_SET_I    = 8'h22;
   localparam logic [7:0] CMD_SET_P    = 8'h23;
   localparam logic [7:0] CMD_READ_M   = 8'h26;
   localparam logic [7:0] CMD_RATINGS  = 8'h27;
   localparam logic [7:0] CMD_READ_SP  = 8'h28;
   localparam logic [7:0] CMD_SET_ID   = 8'h29;
   localparam logic [7:0] CMD_STATUS   = 8'h2a;

   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_ON    = 3'd1;
   localparam logic [2:0] ACT_DELAY = 3'd2;
   localparam logic [2:0] ACT_CYCLE = 3'd3;
   localparam logic [2:0] ACT_OFF   = 3'd4;

   localparam logic [1:0] MODE_CV = 2'd0;
   localparam logic [1:0] MODE_CC = 2'd1;
   localparam logic [1:0] MODE_CP = 2'd2;

   localparam logic       REG_DELAY_EN = 1'b0;
   localparam logic       REG_CYCLE_EN = 1'b1;

   typedef enum logic [2:0] {
      ST_RX,      // taking bytes
      ST_CHECK,   // reading buffer, running the CRC
      ST_FETCH,   // reading the command bytes 1, 3, 4
      ST_EXEC,    // executing the command
      ST_REPLY    // sending reply items
   } state_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### design/supply_command_frame_slave_top.sv
// ----------------------------------------------------------------------------
// supply_command_frame_slave_top: Modbus-RTU style command slave
// Buffers a frame, checks address and CRC, runs one command, sends a reply.
// ----------------------------------------------------------------------------
// A received byte is one item on the req_ channel; tlast marks the last byte
// of a frame. Bytes are written into a frame memory (one write port, one
// registered read port). Bytes not ending a frame are taken back to back.
// At frame end the controller reads the frame back one byte a cycle through
// the memory read port, folding each byte into the CRC. It then reads the
// command bytes through the same registered read port, decodes and
// executes the command in the execute state, and sends
// the reply: one item per cycle on rsp_ as long as rsp_tready is high, up to
// 14 items with the CRC appended. No new byte is accepted until the last
// reply item has been formed; that item may still wait in the output register
// while the next frame comes in. The measured voltage and current taken are
// those carried with the frame's last byte. A reply item is held in an output
// register until it is taken, and the next one is loaded on the same edge, so
// a reply streams without gaps. Frames shorter than four bytes, longer than
// the buffer, from a foreign address or with a bad CRC are dropped silently,
// as are unknown commands.
`default_nettype none
module supply_command_frame_slave_top
   import scfs_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // rx_byte, measured_voltage, measured_current
   input  wire logic        req_tlast,   // frame_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // tx_byte
   output logic             rsp_tlast,   // tx_last
   output logic [5:0]       rsp_tuser,   // output_action, save_request, regulation_mode
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic        csr_wdata
);
   localparam int AW = $clog2(FRAME_BYTES);
   localparam int CW = $clog2(FRAME_BYTES + 1);

   // Frame memory.
   logic [7:0]    mem [FRAME_BYTES];
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= req_tdata[7:0];
      mem_rdata_ff <= mem[mem_raddr];
   end

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] idx_ff, idx_in;      // read address issued
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    addr_b_ff, addr_b_in, crc_lo_ff, crc_lo_in;
   logic [7:0]    cmd_ff, cmd_in, b3_ff, b3_in, b4_ff, b4_in;
   logic [15:0]   mv_ff, mv_in, mc_ff, mc_in;
   logic [7:0]    node_ff, node_in;
   logic [15:0]   vsp_ff, vsp_in, isp_ff, isp_in, psp_ff, psp_in;
   logic [1:0]    mode_ff, mode_in;
   logic          oen_ff, oen_in, dly_en_ff, cyc_en_ff;
   logic [2:0]    act_ff, act_in;
   logic          save_ff, save_in;
   logic [7:0]    rep_ff [14];
   logic [7:0]    rep_in [14];
   logic [3:0]    rlen_ff, rlen_in, rpos_ff, rpos_in;
   logic          ovalid_ff, ovalid_in, olast_ff, olast_in;
   logic [7:0]    obyte_ff, obyte_in;
   logic [5:0]    ouser_ff, ouser_in;

   assign req_tready = (state_ff == ST_RX);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = obyte_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = ouser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_en_ff <= 1'b0;
         cyc_en_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == REG_DELAY_EN) dly_en_ff <= csr_wdata;
         if (csr_index == REG_CYCLE_EN) cyc_en_ff <= csr_wdata;
      end
   end

   always_comb begin
      logic          take;
      logic [15:0]   d;
      logic [3:0]    n;
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      addr_b_in = addr_b_ff;
      crc_lo_in = crc_lo_ff;
      cmd_in    = cmd_ff;
      b3_in     = b3_ff;
      b4_in     = b4_ff;
      mv_in     = mv_ff;
      mc_in     = mc_ff;
      node_in   = node_ff;
      vsp_in    = vsp_ff;
      isp_in    = isp_ff;
      psp_in    = psp_ff;
      mode_in   = mode_ff;
      oen_in    = oen_ff;
      act_in    = act_ff;
      save_in   = save_ff;
      rep_in    = rep_ff;
      rlen_in   = rlen_ff;
      rpos_in   = rpos_ff;
      ovalid_in = ovalid_ff;
      olast_in  = olast_ff;
      obyte_in  = obyte_ff;
      ouser_in  = ouser_ff;
      mem_we    = 1'b0;
      mem_waddr = count_ff[AW-1:0];
      mem_raddr = idx_ff[AW-1:0];
      d = 16'h0;
      n = 4'd0;
      take = rsp_tready || !ovalid_ff;
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;

      case (state_ff)
         ST_RX: begin
            if (req_tvalid) begin
               if (count_ff < CW'(FRAME_BYTES)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  mv_in    = req_tdata[23:8];
                  mc_in    = req_tdata[39:24];
                  count_in = '0;
                  ovf_in   = 1'b0;
                  idx_in   = '0;
                  crc_in   = 16'hFFFF;
                  if (!ovf_ff && count_ff < CW'(FRAME_BYTES)
                      && count_ff + 1'b1 >= CW'(4)) begin
                     // count_ff now holds the frame length minus one
                     count_in = count_ff + 1'b1;
                     state_in = ST_CHECK;
                  end
               end
            end
         end
         ST_CHECK: begin
            // idx_ff is the address issued this cycle; data of idx_ff-1 is out
            if (idx_ff != '0) begin
               if (idx_ff - 1'b1 == '0) addr_b_in = mem_rdata_ff;
               if (idx_ff - 1'b1 < count_ff - CW'(2))
                  crc_in = crc_byte(crc_ff, mem_rdata_ff);
               else if (idx_ff - 1'b1 == count_ff - CW'(2))
                  crc_lo_in = mem_rdata_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == count_ff) begin
               count_in = '0;
               if ((addr_b_ff == node_ff || addr_b_ff == 8'h00)
                   && {mem_rdata_ff, crc_lo_ff} == crc_ff) begin
                  idx_in   = CW'(1);
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_RX;
               end
            end
         end
         ST_FETCH: begin
            // read bytes 1, 3, 4 (byte 2 read but unused)
            if (idx_ff == CW'(2)) cmd_in = mem_rdata_ff;
            if (idx_ff == CW'(4)) b3_in  = mem_rdata_ff;
            if (idx_ff == CW'(5)) b4_in  = mem_rdata_ff;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CW'(5)) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            d = {b3_ff, b4_ff};
            act_in  = ACT_NONE;
            save_in = 1'b0;
            for (int k = 0; k < 14; k++) rep_in[k] = 8'h00;
            rep_in[0] = node_ff;
            rep_in[1] = cmd_ff;
            state_in  = ST_REPLY;
            case (cmd_ff)
               CMD_OUTPUT: begin
                  if (b3_ff == 8'h01) begin
                     if (dly_en_ff) act_in = ACT_DELAY;
                     else if (cyc_en_ff) act_in = ACT_CYCLE;
                     else begin
                        act_in = ACT_ON;
                        oen_in = 1'b1;
                     end
                  end else begin
                     act_in = ACT_OFF;
                     oen_in = 1'b0;
                  end
                  rep_in[2] = 8'h01; rep_in[3] = b3_ff; n = 4'd4;
               end
               CMD_SET_V, CMD_SET_I, CMD_SET_P: begin
                  if (cmd_ff == CMD_SET_V) begin
                     vsp_in = d; mode_in = MODE_CV;
                  end else if (cmd_ff == CMD_SET_I) begin
                     isp_in = d; mode_in = MODE_CC;
                  end else begin
                     psp_in = d; mode_in = MODE_CP;
                  end
                  save_in = 1'b1;
                  rep_in[2] = 8'h02; rep_in[3] = b3_ff; rep_in[4] = b4_ff; n = 4'd5;
               end
               CMD_READ_M: begin
                  rep_in[2] = 8'h04;
                  rep_in[3] = mv_ff[15:8]; rep_in[4] = mv_ff[7:0];
                  rep_in[5] = mc_ff[15:8]; rep_in[6] = mc_ff[7:0];
                  n = 4'd7;
               end
               CMD_RATINGS: begin
                  rep_in[2] = 8'h06;
                  rep_in[3] = 8'h1F; rep_in[4] = 8'h40; rep_in[5] = 8'h02;
                  rep_in[6] = 8'h27; rep_in[7] = 8'h10; rep_in[8] = 8'h02;
                  rep_in[9] = 8'h17; rep_in[10] = 8'h70; rep_in[11] = 8'h00;
                  n = 4'd12;
               end
               CMD_READ_SP: begin
                  rep_in[2] = 8'h05; rep_in[3] = {7'h0, oen_ff};
                  rep_in[4] = vsp_ff[15:8]; rep_in[5] = vsp_ff[7:0];
                  rep_in[6] = isp_ff[15:8]; rep_in[7] = isp_ff[7:0];
                  n = 4'd8;
               end
               CMD_SET_ID: begin
                  rep_in[2] = 8'h01; rep_in[3] = b3_ff;
                  node_in = b3_ff; n = 4'd4;
               end
               CMD_STATUS: begin
                  rep_in[2] = 8'h05; rep_in[3] = {7'h0, oen_ff};
                  rep_in[4] = mv_ff[15:8]; rep_in[5] = mv_ff[7:0];
                  rep_in[6] = mc_ff[15:8]; rep_in[7] = mc_ff[7:0];
                  n = 4'd8;
               end
               default: state_in = ST_RX;
            endcase
            rlen_in = n;
            rpos_in = '0;
            crc_in  = 16'hFFFF;
         end
         ST_REPLY: begin
            // body bytes feed the CRC as they go out; then the two CRC bytes
            if (take) begin
               ovalid_in = 1'b1;
               ouser_in  = {mode_ff, save_ff, act_ff};
               rpos_in   = rpos_ff + 1'b1;
               olast_in  = 1'b0;
               if (rpos_ff < rlen_ff) begin
                  obyte_in = rep_ff[rpos_ff];
                  crc_in   = crc_byte(crc_ff, rep_ff[rpos_ff]);
               end else if (rpos_ff == rlen_ff) begin
                  obyte_in = crc_ff[7:0];
               end else begin
                  obyte_in = crc_ff[15:8];
                  olast_in = 1'b1;
                  state_in = ST_RX;
               end
            end
         end
         default: state_in = ST_RX;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RX;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         node_ff   <= 8'h01;
         vsp_ff    <= '0;
         isp_ff    <= '0;
         psp_ff    <= '0;
         mode_ff   <= MODE_CV;
         oen_ff    <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         node_ff   <= node_in;
         vsp_ff    <= vsp_in;
         isp_ff    <= isp_in;
         psp_ff    <= psp_in;
         mode_ff   <= mode_in;
         oen_ff    <= oen_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      crc_ff    <= crc_in;
      addr_b_ff <= addr_b_in;
      crc_lo_ff <= crc_lo_in;
      cmd_ff    <= cmd_in;
      b3_ff     <= b3_in;
      b4_ff     <= b4_in;
      mv_ff     <= mv_in;
      mc_ff     <= mc_in;
      act_ff    <= act_in;
      save_ff   <= save_in;
      rep_ff    <= rep_in;
      rlen_ff   <= rlen_in;
      rpos_ff   <= rpos_in;
      olast_ff  <= olast_in;
      obyte_ff  <= obyte_in;
      ouser_ff  <= ouser_in;
   end

endmodule
`default_nettype wire

### design/scfs_checker.sv
// ----------------------------------------------------------------------------
// scfs_checker: port-level checks of the supply command frame slave
// Watches the stream ports and reports protocol or behavior slips.
// ----------------------------------------------------------------------------
`default_nettype none
module scfs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic       rsp_tlast,
   input wire logic [7:0] rsp_tdata,
   input wire logic [5:0] rsp_tuser
);
   // A stalled reply item holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled reply item changed");
   // No byte is taken while a reply is still pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken during reply");
   // Action and mode codes stay in range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[2:0] <= 3'd4 && rsp_tuser[5:4] != 2'd3)
      else $error("reply flags out of range");
   // Flags are constant across one reply.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid |-> $stable(rsp_tuser))
      else $error("reply flags changed within a reply");
endmodule

bind supply_command_frame_slave_top scfs_checker u_scfs_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tlast(rsp_tlast),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
`default_nettype wire
